/* rtl/i2a_pkg.sv */
// Package for the integer-to-ASCII block: payload structs, mode codes, ASCII
// constants and the digit-to-character function.
// No dependencies.
package i2a_pkg;

    // Mode codes
    localparam logic [1:0] MODE_UDEC = 2'd0;
    localparam logic [1:0] MODE_SDEC = 2'd1;
    localparam logic [1:0] MODE_OCT  = 2'd2;
    localparam logic [1:0] MODE_HEX  = 2'd3;

    // Digit counts loaded per radix
    localparam logic [3:0] NDIG_DEC = 4'd10;
    localparam logic [3:0] NDIG_OCT = 4'd11;
    localparam logic [3:0] NDIG_HEX = 4'd8;

    // ASCII codes
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_UPA   = 8'h41;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_LO_O  = 8'h6F;
    localparam logic [7:0] ASCII_LO_X  = 8'h78;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  mode;
    } t_in_item;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } t_out_item;

    // Control from the sequencer to the digit unit
    typedef struct packed {
        logic       load;
        logic [1:0] mode;
        logic       shift;
    } t_dig_ctrl;

    // Status from the digit unit
    typedef struct packed {
        logic       busy;
        logic [3:0] top_digit;
        logic       single;
    } t_dig_stat;

    // One digit 0..15 to uppercase ASCII
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = ASCII_ZERO + {4'd0, d};
        end else begin
            c = ASCII_UPA + {4'd0, d - 4'd10};
        end
        return c;
    endfunction

endpackage

/* rtl/integer_to_ascii_radix.sv */
// Integer to ASCII text in unsigned/signed decimal, octal or hex.
// Decimal: bit-serial conversion, leading-zero skip and a handoff state come between the
// input transfer and the first character; octal/hex have only the skip and the handoff.
// Then one character per cycle while the receiver is ready, up to 13. One value at a time:
// a new value is taken only once the last character of the previous one has been sent.
// Synchronous active-low reset returns to idle.
module integer_to_ascii_radix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  i2a_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output i2a_pkg::t_out_item o_data
);

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_WAIT = 3'd1;
    localparam logic [2:0] T_PRE  = 3'd2;
    localparam logic [2:0] T_DIG  = 3'd3;
    localparam logic [2:0] T_SUF  = 3'd4;

    logic [2:0] r_state, n_state;
    logic [1:0] r_mode, n_mode;
    logic [1:0] r_pre, n_pre;

    logic               in_xfer;
    logic               out_xfer;
    logic               neg;
    logic [31:0]        mag;
    i2a_pkg::t_dig_ctrl dig_ctrl;
    i2a_pkg::t_dig_stat dig_stat;

    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = o_valid && i_ready;

    // Signed magnitude
    assign neg = (i_data.mode == i2a_pkg::MODE_SDEC) && i_data.value[31];
    assign mag = neg ? (32'd0 - i_data.value) : i_data.value;

    assign dig_ctrl.load  = in_xfer;
    assign dig_ctrl.mode  = i_data.mode;
    assign dig_ctrl.shift = (r_state == T_DIG) && out_xfer && !dig_stat.single;

    i2a_digits u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (dig_ctrl),
        .i_mag   (mag),
        .o_stat  (dig_stat)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_pre   = r_pre;
        case (r_state)
            T_IDLE: begin
                if (in_xfer) begin
                    n_mode  = i_data.mode;
                    n_state = T_WAIT;
                    if ((i_data.mode == i2a_pkg::MODE_OCT) ||
                        (i_data.mode == i2a_pkg::MODE_HEX)) begin
                        n_pre = 2'd2;
                    end else if (neg) begin
                        n_pre = 2'd1;
                    end else begin
                        n_pre = 2'd0;
                    end
                end
            end
            T_WAIT: begin
                if (!dig_stat.busy) begin
                    n_state = (r_pre != 2'd0) ? T_PRE : T_DIG;
                end
            end
            T_PRE: begin
                if (out_xfer) begin
                    n_pre = r_pre - 2'd1;
                    if (r_pre == 2'd1) begin
                        n_state = T_DIG;
                    end
                end
            end
            T_DIG: begin
                if (out_xfer && dig_stat.single) begin
                    n_state = (r_mode == i2a_pkg::MODE_UDEC) ? T_SUF : T_IDLE;
                end
            end
            T_SUF: begin
                if (out_xfer) begin
                    n_state = T_IDLE;
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_mode <= n_mode;
        r_pre  <= n_pre;
    end

    // Character selection, driven from registers only
    always_comb begin
        o_data.char_code = i2a_pkg::ASCII_SPACE;
        o_data.last      = 1'b0;
        case (r_state)
            T_PRE: begin
                if (r_mode == i2a_pkg::MODE_SDEC) begin
                    o_data.char_code = i2a_pkg::ASCII_MINUS;
                end else if (r_pre == 2'd2) begin
                    o_data.char_code = i2a_pkg::ASCII_ZERO;
                end else if (r_mode == i2a_pkg::MODE_OCT) begin
                    o_data.char_code = i2a_pkg::ASCII_LO_O;
                end else begin
                    o_data.char_code = i2a_pkg::ASCII_LO_X;
                end
            end
            T_DIG: begin
                o_data.char_code = i2a_pkg::digit_char(dig_stat.top_digit);
                o_data.last      = dig_stat.single && (r_mode != i2a_pkg::MODE_UDEC);
            end
            T_SUF: begin
                o_data.last = 1'b1;
            end
            default: begin
                o_data.last = 1'b0;
            end
        endcase
    end

    assign o_ready = (r_state == T_IDLE);
    assign o_valid = (r_state == T_PRE) || (r_state == T_DIG) || (r_state == T_SUF);

endmodule

/* rtl/i2a_digits.sv */
// Digit unit: bit-serial binary-to-BCD (shift and add three) for decimal,
// direct digit split for octal and hex, then leading-zero skip.
// Depends on i2a_pkg.
module i2a_digits (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  i2a_pkg::t_dig_ctrl  i_ctrl,
    input  logic [31:0]         i_mag,
    output i2a_pkg::t_dig_stat  o_stat
);

    localparam logic [1:0] D_READY = 2'd0;
    localparam logic [1:0] D_CONV  = 2'd1;
    localparam logic [1:0] D_SKIP  = 2'd2;

    logic [1:0]  r_phase, n_phase;
    logic [43:0] r_dig, n_dig;
    logic [31:0] r_bin, n_bin;
    logic [4:0]  r_cnt, n_cnt;
    logic [3:0]  r_ndig, n_ndig;

    logic [39:0] bcd_adj;
    logic [43:0] oct_dig;
    logic        top_zero;

    // Add three to every BCD digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < 10; i++) begin
            if (r_dig[4*i+4 +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = r_dig[4*i+4 +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = r_dig[4*i+4 +: 4];
            end
        end
    end

    // Octal digits: three bits each, top digit takes the last two bits
    always_comb begin
        for (int i = 0; i < 10; i++) begin
            oct_dig[4*i +: 4] = {1'b0, i_mag[3*i +: 3]};
        end
        oct_dig[43:40] = {2'b00, i_mag[31:30]};
    end

    assign top_zero = (r_dig[43:40] == 4'd0);

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_dig   = r_dig;
        n_bin   = r_bin;
        n_cnt   = r_cnt;
        n_ndig  = r_ndig;
        if (i_ctrl.load) begin
            n_cnt = 5'd0;
            n_bin = i_mag;
            case (i_ctrl.mode)
                i2a_pkg::MODE_UDEC, i2a_pkg::MODE_SDEC: begin
                    n_dig   = '0;
                    n_ndig  = i2a_pkg::NDIG_DEC;
                    n_phase = D_CONV;
                end
                i2a_pkg::MODE_OCT: begin
                    n_dig   = oct_dig;
                    n_ndig  = i2a_pkg::NDIG_OCT;
                    n_phase = D_SKIP;
                end
                default: begin
                    n_dig   = {i_mag, 12'h000};
                    n_ndig  = i2a_pkg::NDIG_HEX;
                    n_phase = D_SKIP;
                end
            endcase
        end else begin
            case (r_phase)
                D_CONV: begin
                    // One binary bit enters the BCD digits per cycle
                    n_dig   = {bcd_adj[38:0], r_bin[31], 4'h0};
                    n_bin   = {r_bin[30:0], 1'b0};
                    n_cnt   = r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        n_phase = D_SKIP;
                    end
                end
                D_SKIP: begin
                    // Drop one leading zero per cycle, keep at least one digit
                    if (top_zero && (r_ndig > 4'd1)) begin
                        n_dig  = {r_dig[39:0], 4'h0};
                        n_ndig = r_ndig - 4'd1;
                    end else begin
                        n_phase = D_READY;
                    end
                end
                D_READY: begin
                    if (i_ctrl.shift) begin
                        n_dig  = {r_dig[39:0], 4'h0};
                        n_ndig = r_ndig - 4'd1;
                    end
                end
                default: begin
                    n_phase = D_READY;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= D_READY;
        end else begin
            r_phase <= n_phase;
        end
        r_dig  <= n_dig;
        r_bin  <= n_bin;
        r_cnt  <= n_cnt;
        r_ndig <= n_ndig;
    end

    assign o_stat.busy      = (r_phase != D_READY);
    assign o_stat.top_digit = r_dig[43:40];
    assign o_stat.single    = (r_ndig == 4'd1);

endmodule

/* rtl/i2a_check.sv */
// Port-level checker for integer_to_ascii_radix, with its bind statement.
// Depends on i2a_pkg.
module i2a_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input i2a_pkg::t_in_item  i_data,
    input logic               o_valid,
    input logic               i_ready,
    input i2a_pkg::t_out_item o_data
);

    // A stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("output changed while stalled");

    // No new value is taken while characters are pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while text pending");

    // After an input transfer the block is busy
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input ready right after transfer");

    // Characters of one value follow without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_data.last) |=> o_valid)
        else $error("gap inside text");

    // The last character ends the text and frees the input
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_data.last) |=> (!o_valid && o_ready))
        else $error("text did not end after last");

endmodule

bind integer_to_ascii_radix i2a_check u_i2a_check (.*);

/* bench/testbench.sv */
// Self-checking bench for integer_to_ascii_radix: random and corner values in every mode,
// with the expected character stream built in the bench and compared per transfer.
// Depends on rtl/i2a_pkg.sv and rtl/integer_to_ascii_radix.sv.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUM_RANDOM   = 430;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    // Conversion plus skip plus longest text, with some margin
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam logic [127:0] DIGIT_SET   = "0123456789ABCDEF";

    // Expected character stream, built from each accepted value
    class expected_text;
        i2a_pkg::t_out_item chars_due[$];
        int unsigned        errors;

        function new();
            errors = 0;
        endfunction

        // Queue the text that one accepted value must produce
        function void add_value(logic [31:0] value, logic [1:0] mode);
            logic [7:0]         text[$];
            logic [7:0]         digits[$];
            logic [31:0]        mag;
            logic [31:0]        radix;
            logic [3:0]         d;
            i2a_pkg::t_out_item item;
            mag   = value;
            radix = 32'd10;
            case (mode)
                i2a_pkg::MODE_SDEC: begin
                    if (value[31]) begin
                        text.push_back(i2a_pkg::ASCII_MINUS);
                        mag = 32'd0 - value;
                    end
                end
                i2a_pkg::MODE_OCT: begin
                    text.push_back(i2a_pkg::ASCII_ZERO);
                    text.push_back(i2a_pkg::ASCII_LO_O);
                    radix = 32'd8;
                end
                i2a_pkg::MODE_HEX: begin
                    text.push_back(i2a_pkg::ASCII_ZERO);
                    text.push_back(i2a_pkg::ASCII_LO_X);
                    radix = 32'd16;
                end
                default: ;
            endcase
            // Digits come out least significant first; a zero gives one digit
            do begin
                d = 4'(mag % radix);
                digits.push_front(DIGIT_SET[8 * (15 - d) +: 8]);
                mag = mag / radix;
            end while (mag != 32'd0);
            foreach (digits[i]) text.push_back(digits[i]);
            if (mode == i2a_pkg::MODE_UDEC) text.push_back(i2a_pkg::ASCII_SPACE);
            foreach (text[i]) begin
                item.char_code = text[i];
                item.last      = (i == text.size() - 1);
                chars_due.push_back(item);
            end
        endfunction

        // Compare one output transfer with the oldest expected character
        function void check_char(i2a_pkg::t_out_item got);
            i2a_pkg::t_out_item want;
            if (chars_due.size() == 0) begin
                $error("unexpected char_code %0h last %0b", got.char_code, got.last);
                errors++;
                return;
            end
            want = chars_due.pop_front();
            if (got.char_code !== want.char_code) begin
                $error("char_code: expected %0h, got %0h", want.char_code, got.char_code);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    i2a_pkg::t_in_item  i_data;
    logic               o_valid;
    logic               i_ready;
    i2a_pkg::t_out_item o_data;

    expected_text text_sb = new();
    int unsigned  send_idle_pct;
    int unsigned  recv_idle_pct;
    int unsigned  cycle_count;

    integer_to_ascii_radix dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver side: random back-pressure, held off during reset
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Output transfers go to the checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            text_sb.check_char(o_data);
        end
    end

    // Run guard
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // One value transfer; valid is only lowered when a gap is taken
    task automatic send_value(input logic [31:0] value, input logic [1:0] mode);
        i2a_pkg::t_in_item item;
        item.value = value;
        item.mode  = mode;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        do @(posedge i_clk); while (!o_ready);
        text_sb.add_value(value, mode);
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (text_sb.chars_due.size() != 0) @(posedge i_clk);
    endtask

    // Mix of full-range, small, power-of-two and small negative values
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(3))
            0: v = $urandom();
            1: v = $urandom_range(20);
            2: v = (32'd1 << $urandom_range(31)) + 32'($urandom_range(2)) - 32'd1;
            default: v = 32'd0 - 32'($urandom_range(1, 20));
        endcase
        return v;
    endfunction

    task automatic random_values(input int unsigned count, input int unsigned send_pct,
                                 input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_value(pick_value(), 2'($urandom_range(3)));
    endtask

    initial begin
        logic [31:0] corner_vals[5];
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_data        <= '0;
        send_idle_pct = 7;
        recv_idle_pct = 61;
        corner_vals   = '{32'd0, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero, one, largest positive, most negative and all ones in every mode
        foreach (corner_vals[i]) begin
            send_value(corner_vals[i], i2a_pkg::MODE_UDEC);
            send_value(corner_vals[i], i2a_pkg::MODE_SDEC);
            send_value(corner_vals[i], i2a_pkg::MODE_OCT);
            send_value(corner_vals[i], i2a_pkg::MODE_HEX);
        end
        // First two-digit values per radix
        send_value(32'd10, i2a_pkg::MODE_UDEC);
        send_value(32'd8, i2a_pkg::MODE_OCT);
        send_value(32'd16, i2a_pkg::MODE_HEX);

        // Sender holds off until the output side is empty
        wait_for_drain();

        random_values(NUM_RANDOM / 3, 7, 61);
        random_values(NUM_RANDOM / 3, 61, 7);
        random_values(NUM_RANDOM - 2 * (NUM_RANDOM / 3), 0, 0);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (text_sb.errors == 0 && text_sb.chars_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
